/* hw/rtl/dsrl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_pkg
// Shared constants, request and status codes, and the command and status
// structs that join the controller and the datapath of the scan record log.
// ----------------------------------------------------------------------------
package dsrl_pkg;

  localparam int LOG_DEPTH_DEF     = 64;
  localparam int ADDRESS_SLOTS_DEF = 16;

  localparam int ADDR_W      = 48;
  localparam int TIME_W      = 32;
  localparam int STR_W       = 8;
  localparam int REQ_W       = 2;
  localparam int IDX_IN_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int SEL_OUT_W   = 6;

  localparam logic [TIME_W-1:0] TICK_RATE_RESET = 32'd48000000;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SELECT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOG_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic accept;
    logic op_select;
    logic op_clear;
    logic search_start;
    logic search_rd;
    logic search_cmp;
    logic commit_add;
    logic rec_read;
    logic addr_read;
    logic div_start;
    logic load_out;
  } dsrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             table_empty;
    logic             match;
    logic             search_last;
    logic             div_busy;
  } dsrl_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/dsrl_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_div
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// yields an all-ones quotient.
// ----------------------------------------------------------------------------
module dsrl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dsrl_pkg::TIME_W-1:0] dividend,
  input  logic [dsrl_pkg::TIME_W-1:0] divisor,
  output logic                        busy,
  output logic [dsrl_pkg::TIME_W-1:0] quotient
);
  import dsrl_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;

  assign shifted = {rem, quotient[TIME_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(TIME_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[TIME_W]) begin
        rem      <= diff[TIME_W-1:0];
        quotient <= {quotient[TIME_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[TIME_W-1:0];
        quotient <= {quotient[TIME_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/dsrl_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_datapath
// Address table, record memories, counters, age arithmetic and the result
// register. All but tick rate writes start on a command from the controller.
// ----------------------------------------------------------------------------
module dsrl_datapath #(
  parameter int LOG_DEPTH     = dsrl_pkg::LOG_DEPTH_DEF,
  parameter int ADDRESS_SLOTS = dsrl_pkg::ADDRESS_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dsrl_pkg::dsrl_cmd_t                cmd,
  output dsrl_pkg::dsrl_sts_t                sts,
  input  logic                               cfg_wr,
  input  logic [dsrl_pkg::TIME_W-1:0]        cfg_data,
  input  logic [dsrl_pkg::REQ_W-1:0]         req_type,
  input  logic [dsrl_pkg::ADDR_W-1:0]        device_address,
  input  logic signed [dsrl_pkg::STR_W-1:0]  signal_strength,
  input  logic [dsrl_pkg::TIME_W-1:0]        report_time,
  input  logic [dsrl_pkg::IDX_IN_W-1:0]      record_index,
  input  logic [dsrl_pkg::TIME_W-1:0]        current_time,
  output logic [dsrl_pkg::STATUS_W-1:0]      status,
  output logic [dsrl_pkg::COUNT_OUT_W-1:0]   record_count,
  output logic [dsrl_pkg::SEL_OUT_W-1:0]     selected_record,
  output logic [dsrl_pkg::ADDR_W-1:0]        record_address,
  output logic [dsrl_pkg::STR_W-1:0]         strength_magnitude,
  output logic [dsrl_pkg::TIME_W-1:0]        record_age,
  output logic                               address_overflow
);
  import dsrl_pkg::*;

  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int IDX_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int ACNT_W = $clog2(ADDRESS_SLOTS + 1);
  localparam int SLOT_W = (ADDRESS_SLOTS > 1) ? $clog2(ADDRESS_SLOTS) : 1;

  // Latched request.
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [STR_W-1:0]  strength_q;
  logic [TIME_W-1:0] rtime_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic [TIME_W-1:0] now_q;

  // Control state.
  logic [TIME_W-1:0] tick_rate;
  logic [ACNT_W-1:0] address_count;
  logic [CNT_W-1:0]  log_count;
  logic [IDX_W-1:0]  selection;
  logic              overflow_flag;
  logic              found;
  logic [SLOT_W-1:0] found_slot;
  logic [SLOT_W-1:0] search_idx;
  logic [STATUS_W-1:0] status_q;

  // Memories and their registered read data.
  logic [ADDR_W-1:0] address_table [ADDRESS_SLOTS];
  logic [TIME_W-1:0] stamp_mem     [LOG_DEPTH];
  logic [STR_W-1:0]  strength_mem  [LOG_DEPTH];
  logic [SLOT_W-1:0] slot_mem      [LOG_DEPTH];
  logic [ADDR_W-1:0] table_rdata;
  logic [TIME_W-1:0] stamp_rdata;
  logic [STR_W-1:0]  strength_rdata;
  logic [SLOT_W-1:0] slot_rdata;

  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] scaled;
  logic [TIME_W-1:0] quotient;
  logic              div_busy;

  logic table_full;
  logic log_full;
  logic add_ok;
  logic tbl_we;
  logic rec_we;
  logic tbl_re;
  logic [SLOT_W-1:0] tbl_ra;
  logic [SLOT_W-1:0] new_slot;
  logic idx_in_range;

  assign table_full   = address_count >= ACNT_W'(ADDRESS_SLOTS);
  assign log_full     = log_count >= CNT_W'(LOG_DEPTH);
  assign add_ok       = (found || !table_full) && !log_full;
  assign rec_we       = cmd.commit_add && add_ok;
  assign tbl_we       = rec_we && !found;
  assign new_slot     = found ? found_slot : address_count[SLOT_W-1:0];
  assign tbl_re       = cmd.search_rd || cmd.addr_read;
  assign tbl_ra       = cmd.search_rd ? search_idx : slot_rdata;
  assign idx_in_range = 32'(idx_q) < 32'(log_count);

  // Age numerator: wrapped (now - stamp) * 10, as shift-and-add.
  assign diff   = now_q - stamp_rdata;
  assign scaled = (diff << 3) + (diff << 1);

  assign sts.req         = req_q;
  assign sts.table_empty = address_count == '0;
  assign sts.match       = table_rdata == addr_q;
  assign sts.search_last = (ACNT_W'(search_idx) + ACNT_W'(1)) == address_count;
  assign sts.div_busy    = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q      <= req_type;
      addr_q     <= device_address;
      strength_q <= signal_strength;
      rtime_q    <= report_time;
      idx_q      <= record_index;
      now_q      <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate     <= TICK_RATE_RESET;
      address_count <= '0;
      log_count     <= '0;
      selection     <= '0;
      overflow_flag <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tick_rate <= cfg_data;
      end
      if (cmd.search_start) begin
        found <= 1'b0;
      end else if (cmd.search_cmp && sts.match) begin
        found <= 1'b1;
      end
      if (cmd.op_select && idx_in_range) begin
        selection <= idx_q[IDX_W-1:0];
      end
      if (cmd.op_clear) begin
        address_count <= '0;
        log_count     <= '0;
        selection     <= '0;
        overflow_flag <= 1'b0;
      end
      if (cmd.commit_add) begin
        if (!found && table_full) begin
          overflow_flag <= 1'b1;
        end
        if (rec_we) begin
          log_count <= log_count + CNT_W'(1);
        end
        if (tbl_we) begin
          address_count <= address_count + ACNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_q <= ST_DONE;
    end else if (cmd.op_select) begin
      status_q <= (log_count == '0) ? ST_EMPTY : ST_DONE;
    end else if (cmd.commit_add) begin
      if (!found && table_full) begin
        status_q <= ST_TABLE_FULL;
      end else if (log_full) begin
        status_q <= ST_LOG_FULL;
      end else begin
        status_q <= ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      search_idx <= '0;
    end else if (cmd.search_cmp) begin
      if (sts.match) begin
        found_slot <= search_idx;
      end else begin
        search_idx <= search_idx + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      address_table[address_count[SLOT_W-1:0]] <= addr_q;
    end
    if (tbl_re) begin
      table_rdata <= address_table[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      stamp_mem[log_count[IDX_W-1:0]]    <= rtime_q;
      strength_mem[log_count[IDX_W-1:0]] <= STR_W'(8'd0 - strength_q);
      slot_mem[log_count[IDX_W-1:0]]     <= new_slot;
    end
    if (cmd.rec_read) begin
      stamp_rdata    <= stamp_mem[selection];
      strength_rdata <= strength_mem[selection];
      slot_rdata     <= slot_mem[selection];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_read) begin
      delta <= scaled;
    end
  end

  dsrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (delta),
    .divisor  (tick_rate),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Result register; the record fields read as zero on an empty log.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status           <= status_q;
      record_count     <= COUNT_OUT_W'(log_count);
      selected_record  <= SEL_OUT_W'(selection);
      address_overflow <= overflow_flag;
      if (log_count == '0) begin
        record_address     <= '0;
        strength_magnitude <= '0;
        record_age         <= '0;
      end else begin
        record_address     <= table_rdata;
        strength_magnitude <= strength_rdata;
        record_age         <= quotient;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/dsrl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_ctrl
// Request sequencer: address search, record append, record read, age
// division and hand-off to the result register.
// ----------------------------------------------------------------------------
module dsrl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dsrl_pkg::dsrl_sts_t sts,
  output dsrl_pkg::dsrl_cmd_t cmd
);
  import dsrl_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_COMMIT   = 4'd4;
  localparam logic [3:0] S_RD_REC   = 4'd5;
  localparam logic [3:0] S_RD_ADDR  = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.req)
          REQ_ADD: begin
            cmd.search_start = 1'b1;
            state_next = sts.table_empty ? S_COMMIT : S_SRCH_RD;
          end
          REQ_SELECT: begin
            cmd.op_select = 1'b1;
            state_next = S_RD_REC;
          end
          REQ_CLEAR: begin
            cmd.op_clear = 1'b1;
            state_next = S_RD_REC;
          end
          default: begin
            state_next = S_RD_REC;
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd.search_rd = 1'b1;
        state_next = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd.search_cmp = 1'b1;
        state_next = (sts.match || sts.search_last) ? S_COMMIT : S_SRCH_RD;
      end
      S_COMMIT: begin
        cmd.commit_add = 1'b1;
        state_next = S_RD_REC;
      end
      S_RD_REC: begin
        cmd.rec_read = 1'b1;
        state_next = S_RD_ADDR;
      end
      S_RD_ADDR: begin
        cmd.addr_read = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A new result never overwrites one that is still held by the consumer.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register loaded while a result is stalled");

  // A result appears only out of the hand-off state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result valid raised outside the hand-off state");

  // The divider is finished whenever the sequencer is waiting for a request.
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !sts.div_busy)
    else $error("divider still busy while idle");

endmodule
`default_nettype wire

/* hw/rtl/dedup_scan_record_log.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_scan_record_log
// Scan report log with address deduplication: appends reports, selects and
// reads records, and reports record age in tenths of a second.
// ----------------------------------------------------------------------------
// Sequence: select, clear and unused codes go through dispatch, record read,
// address read and the 32-step age divider to the result register; an add
// first searches the address table entry by entry, then commits the record.
// Throughput: one request at a time; the next is accepted once the result is
// in the output register. Reset clears the counts, the overflow flag and the
// selection and loads tick_rate with 48000000; the memories are not cleared.
module dedup_scan_record_log #(
  parameter int LOG_DEPTH     = dsrl_pkg::LOG_DEPTH_DEF,
  parameter int ADDRESS_SLOTS = dsrl_pkg::ADDRESS_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dsrl_pkg::REQ_W-1:0]         req_type,
  input  logic [dsrl_pkg::ADDR_W-1:0]        device_address,
  input  logic signed [dsrl_pkg::STR_W-1:0]  signal_strength,
  input  logic [dsrl_pkg::TIME_W-1:0]        report_time,
  input  logic [dsrl_pkg::IDX_IN_W-1:0]      record_index,
  input  logic [dsrl_pkg::TIME_W-1:0]        current_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [dsrl_pkg::STATUS_W-1:0]      status,
  output logic [dsrl_pkg::COUNT_OUT_W-1:0]   record_count,
  output logic [dsrl_pkg::SEL_OUT_W-1:0]     selected_record,
  output logic [dsrl_pkg::ADDR_W-1:0]        record_address,
  output logic [dsrl_pkg::STR_W-1:0]         strength_magnitude,
  output logic [dsrl_pkg::TIME_W-1:0]        record_age,
  output logic                               address_overflow,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dsrl_pkg::TIME_W-1:0]        cfg_data
);
  import dsrl_pkg::*;

  dsrl_cmd_t cmd;
  dsrl_sts_t sts;

  // The tick rate register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  dsrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsrl_datapath #(
    .LOG_DEPTH     (LOG_DEPTH),
    .ADDRESS_SLOTS (ADDRESS_SLOTS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .req_type           (req_type),
    .device_address     (device_address),
    .signal_strength    (signal_strength),
    .report_time        (report_time),
    .record_index       (record_index),
    .current_time       (current_time),
    .status             (status),
    .record_count       (record_count),
    .selected_record    (selected_record),
    .record_address     (record_address),
    .strength_magnitude (strength_magnitude),
    .record_age         (record_age),
    .address_overflow   (address_overflow)
  );

endmodule
`default_nettype wire
